// ===== hw/rtl/stq_pkg.sv =====
package stq_pkg;

	// Default sizes
	localparam int QUEUE_DEPTH_DEF  = 16;
	localparam int HANDLER_BITS_DEF = 8;
	localparam int MAX_RESULTS      = 16;
	localparam int SEC_W            = 32;
	localparam int USEC_W           = 20;

	// Request commands
	localparam logic [1:0] CMD_INSERT = 2'd0;
	localparam logic [1:0] CMD_REMOVE = 2'd1;
	localparam logic [1:0] CMD_EXPIRE = 2'd2;

	// Result kinds
	typedef enum logic [2:0] {
		K_INSERTED  = 3'd0,
		K_DROPPED   = 3'd1,
		K_REMOVED   = 3'd2,
		K_NOT_FOUND = 3'd3,
		K_EXPIRED   = 3'd4,
		K_NONE      = 3'd5
	} kind_t;

	// Deadline: seconds then microseconds, compared as one number
	typedef struct packed {
		logic [SEC_W-1:0]  sec;
		logic [USEC_W-1:0] usec;
	} stamp_t;

	// Operation broadcast to every cell
	typedef enum logic [1:0] {
		OP_HOLD   = 2'd0,
		OP_INSERT = 2'd1,
		OP_REMOVE = 2'd2,
		OP_POP    = 2'd3
	} op_t;

	typedef struct packed {
		op_t    op;
		stamp_t key;
	} cell_ctrl_t;

	// a strictly earlier than b
	function automatic logic earlier(stamp_t a, stamp_t b);
		return (a.sec < b.sec) || ((a.sec == b.sec) && (a.usec < b.usec));
	endfunction

endpackage

// ===== hw/rtl/stq_if.sv =====
interface stq_req_if import stq_pkg::*; #(
	parameter int HANDLER_BITS = HANDLER_BITS_DEF
);
	logic                    valid;
	logic                    ready;
	logic [1:0]              cmd;
	logic [SEC_W-1:0]        time_sec;
	logic [USEC_W-1:0]       time_usec;
	logic [HANDLER_BITS-1:0] handler_id;

	modport source (output valid, cmd, time_sec, time_usec, handler_id, input ready);
	modport sink   (input valid, cmd, time_sec, time_usec, handler_id, output ready);
endinterface

interface stq_rsp_if import stq_pkg::*; #(
	parameter int HANDLER_BITS = HANDLER_BITS_DEF,
	parameter int CNT_W        = $clog2(QUEUE_DEPTH_DEF + 1)
);
	logic                    valid;
	logic                    ready;
	kind_t                   kind;
	logic [HANDLER_BITS-1:0] out_handler;
	logic                    is_last;
	logic [CNT_W-1:0]        entries_left;
	logic [SEC_W-1:0]        earliest_sec;
	logic [USEC_W-1:0]       earliest_usec;

	modport source (output valid, kind, out_handler, is_last, entries_left,
		earliest_sec, earliest_usec, input ready);
	modport sink   (input valid, kind, out_handler, is_last, entries_left,
		earliest_sec, earliest_usec, output ready);
endinterface

// ===== hw/rtl/sorted_timer_queue_core.sv =====
// Flow: a request is captured in S_IDLE; its first result is registered in S_EXEC as
// soon as the result register is free. A new request is taken only back in S_IDLE.
// Throughput: an expire gives one result per cycle while the result side does not stall
// (one pop of the cell row per cycle), up to MAX_RESULTS, then ready returns.
// Reset: arst_n clears every cell's valid bit, the count and the control; the queue
// is empty and ready as soon as reset is released. Slot contents are not reset.
module sorted_timer_queue_core import stq_pkg::*; #(
	parameter int QUEUE_DEPTH  = QUEUE_DEPTH_DEF,
	parameter int HANDLER_BITS = HANDLER_BITS_DEF
) (
	input logic      clk,
	input logic      arst_n,
	stq_req_if.sink  in,
	stq_rsp_if.source out
);

	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam int POP_W = $clog2(MAX_RESULTS);

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_EXEC = 2'b10
	} state_t;

	state_t                  state_q;
	logic [1:0]              cmd_q;
	stamp_t                  key_q;
	logic [HANDLER_BITS-1:0] hkey_q;
	logic [CNT_W-1:0]        count_q;
	logic [POP_W-1:0]        pop_cnt_q;

	logic                    out_valid_q;
	kind_t                   kind_q;
	logic [HANDLER_BITS-1:0] out_handler_q;
	logic                    is_last_q;
	logic [CNT_W-1:0]        left_q;
	stamp_t                  earliest_q;

	// Cell row wiring
	cell_ctrl_t              ctrl;
	logic                    cell_valid   [QUEUE_DEPTH];
	logic                    cell_ahead   [QUEUE_DEPTH];
	logic                    cell_due     [QUEUE_DEPTH];
	logic                    cell_seen    [QUEUE_DEPTH];
	stamp_t                  cell_stamp   [QUEUE_DEPTH];
	logic [HANDLER_BITS-1:0] cell_handler [QUEUE_DEPTH];
	stamp_t                  cell_stamp_d [QUEUE_DEPTH];

	// Command decode
	op_t                     op;
	kind_t                   kind;
	logic [HANDLER_BITS-1:0] res_handler;
	logic                    last;
	logic                    cmd_ok;
	logic [CNT_W-1:0]        count_d;
	logic                    exec;
	logic                    out_free;
	logic                    emit;
	logic                    leave;
	logic                    full;

	assign exec     = (state_q == S_EXEC);
	assign out_free = !out_valid_q || out.ready;
	assign full     = (count_q == CNT_W'(QUEUE_DEPTH));
	assign in.ready = (state_q == S_IDLE);

	always_comb begin
		op          = OP_HOLD;
		kind        = K_NONE;
		res_handler = '0;
		last        = 1'b1;
		cmd_ok      = 1'b1;
		count_d     = count_q;
		case (cmd_q)
			CMD_INSERT: begin
				if (full) begin
					kind = K_DROPPED;
				end else begin
					op      = OP_INSERT;
					kind    = K_INSERTED;
					count_d = count_q + 1'b1;
				end
			end
			CMD_REMOVE: begin
				if (cell_seen[QUEUE_DEPTH-1]) begin
					op          = OP_REMOVE;
					kind        = K_REMOVED;
					res_handler = hkey_q;
					count_d     = count_q - 1'b1;
				end else begin
					kind = K_NOT_FOUND;
				end
			end
			CMD_EXPIRE: begin
				if (cell_due[0]) begin
					op          = OP_POP;
					kind        = K_EXPIRED;
					res_handler = cell_handler[0];
					count_d     = count_q - 1'b1;
					last        = (pop_cnt_q == POP_W'(MAX_RESULTS - 1)) || !cell_due[1];
				end
			end
			default: begin
				cmd_ok = 1'b0;
			end
		endcase
	end

	assign emit     = exec && cmd_ok && out_free;
	assign leave    = exec && (!cmd_ok || (out_free && last));
	assign ctrl.op  = emit ? op : OP_HOLD;
	assign ctrl.key = key_q;

	// Row of cells, slot 0 holds the earliest deadline
	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		logic                    l_valid;
		logic                    l_ahead;
		logic                    l_seen;
		stamp_t                  l_stamp;
		logic [HANDLER_BITS-1:0] l_handler;
		logic                    r_valid;
		stamp_t                  r_stamp;
		logic [HANDLER_BITS-1:0] r_handler;

		if (i == 0) begin : g_left_edge
			assign l_valid   = 1'b0;
			assign l_ahead   = 1'b0;
			assign l_seen    = 1'b0;
			assign l_stamp   = '0;
			assign l_handler = '0;
		end else begin : g_left
			assign l_valid   = cell_valid[i-1];
			assign l_ahead   = cell_ahead[i-1];
			assign l_seen    = cell_seen[i-1];
			assign l_stamp   = cell_stamp[i-1];
			assign l_handler = cell_handler[i-1];
		end

		if (i == QUEUE_DEPTH - 1) begin : g_right_edge
			assign r_valid   = 1'b0;
			assign r_stamp   = '0;
			assign r_handler = '0;
		end else begin : g_right
			assign r_valid   = cell_valid[i+1];
			assign r_stamp   = cell_stamp[i+1];
			assign r_handler = cell_handler[i+1];
		end

		stq_cell #(
			.HANDLER_BITS (HANDLER_BITS),
			.IS_HEAD      (i == 0)
		) u_cell (
			.clk           (clk),
			.arst_n        (arst_n),
			.ctrl          (ctrl),
			.key_handler   (hkey_q),
			.left_valid    (l_valid),
			.left_ahead    (l_ahead),
			.left_seen     (l_seen),
			.left_stamp    (l_stamp),
			.left_handler  (l_handler),
			.right_valid   (r_valid),
			.right_stamp   (r_stamp),
			.right_handler (r_handler),
			.valid         (cell_valid[i]),
			.ahead         (cell_ahead[i]),
			.due           (cell_due[i]),
			.seen          (cell_seen[i]),
			.stamp         (cell_stamp[i]),
			.handler       (cell_handler[i]),
			.stamp_d       (cell_stamp_d[i])
		);
	end

	// Control: request capture, count, pop counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			pop_cnt_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (in.valid && in.ready) begin
				state_q   <= S_EXEC;
				pop_cnt_q <= '0;
			end else if (leave) begin
				state_q <= S_IDLE;
			end
			if (emit) begin
				count_q   <= count_d;
				pop_cnt_q <= pop_cnt_q + 1'b1;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Request and result payload
	always_ff @(posedge clk) begin
		if (in.valid && in.ready) begin
			cmd_q  <= in.cmd;
			key_q  <= {in.time_sec, in.time_usec};
			hkey_q <= in.handler_id;
		end
		if (emit) begin
			kind_q        <= kind;
			out_handler_q <= res_handler;
			is_last_q     <= last;
			left_q        <= count_d;
			earliest_q    <= (count_d != '0) ? cell_stamp_d[0] : '0;
		end
	end

	assign out.valid         = out_valid_q;
	assign out.kind          = kind_q;
	assign out.out_handler   = out_handler_q;
	assign out.is_last       = is_last_q;
	assign out.entries_left  = left_q;
	assign out.earliest_sec  = earliest_q.sec;
	assign out.earliest_usec = earliest_q.usec;

endmodule

// ===== hw/rtl/stq_cell.sv =====
module stq_cell import stq_pkg::*; #(
	parameter int HANDLER_BITS = HANDLER_BITS_DEF,
	parameter bit IS_HEAD      = 1'b0
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  cell_ctrl_t              ctrl,
	input  logic [HANDLER_BITS-1:0] key_handler,
	input  logic                    left_valid,
	input  logic                    left_ahead,
	input  logic                    left_seen,
	input  stamp_t                  left_stamp,
	input  logic [HANDLER_BITS-1:0] left_handler,
	input  logic                    right_valid,
	input  stamp_t                  right_stamp,
	input  logic [HANDLER_BITS-1:0] right_handler,
	output logic                    valid,
	output logic                    ahead,
	output logic                    due,
	output logic                    seen,
	output stamp_t                  stamp,
	output logic [HANDLER_BITS-1:0] handler,
	output stamp_t                  stamp_d
);

	logic                    valid_q;
	stamp_t                  stamp_q;
	logic [HANDLER_BITS-1:0] handler_q;
	logic                    valid_d;
	logic [HANDLER_BITS-1:0] handler_d;
	logic                    match;

	// Compares against the broadcast key
	assign due    = valid_q & earlier(stamp_q, ctrl.key);
	// The head lets a new entry of equal time go behind it
	assign ahead  = IS_HEAD ? (valid_q & ~earlier(ctrl.key, stamp_q)) : due;
	assign match  = valid_q && (handler_q == key_handler);
	assign seen   = left_seen | match;

	assign valid   = valid_q;
	assign stamp   = stamp_q;
	assign handler = handler_q;

	// Next contents: keep, take the new entry, or take a neighbour's
	always_comb begin
		valid_d   = valid_q;
		stamp_d   = stamp_q;
		handler_d = handler_q;
		case (ctrl.op)
			OP_INSERT: begin
				if (!ahead) begin
					if (IS_HEAD || left_ahead) begin
						stamp_d   = ctrl.key;
						handler_d = key_handler;
					end else begin
						stamp_d   = left_stamp;
						handler_d = left_handler;
					end
					valid_d = valid_q | left_valid | IS_HEAD;
				end
			end
			OP_REMOVE: begin
				if (seen) begin
					stamp_d   = right_stamp;
					handler_d = right_handler;
					valid_d   = right_valid;
				end
			end
			OP_POP: begin
				stamp_d   = right_stamp;
				handler_d = right_handler;
				valid_d   = right_valid;
			end
			default: begin
				valid_d = valid_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= valid_d;
		end
	end

	always_ff @(posedge clk) begin
		stamp_q   <= stamp_d;
		handler_q <= handler_d;
	end

endmodule

// ===== hw/rtl/stq_checker.sv =====
module stq_checker import stq_pkg::*; #(
	parameter int QUEUE_DEPTH  = QUEUE_DEPTH_DEF,
	parameter int HANDLER_BITS = HANDLER_BITS_DEF,
	parameter int CNT_W        = $clog2(QUEUE_DEPTH + 1)
) (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    out_valid,
	input logic                    out_ready,
	input kind_t                   kind,
	input logic [HANDLER_BITS-1:0] out_handler,
	input logic                    is_last,
	input logic [CNT_W-1:0]        entries_left,
	input logic [SEC_W-1:0]        earliest_sec,
	input logic [USEC_W-1:0]       earliest_usec
);

	// A stalled result holds
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(out_handler)
			&& $stable(entries_left) && $stable(is_last))
		else $error("result changed while stalled");

	// Count never exceeds the row
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> entries_left <= QUEUE_DEPTH)
		else $error("entries_left beyond depth");

	// Empty queue reports a zero deadline
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (entries_left == '0) |-> (earliest_sec == '0) && (earliest_usec == '0))
		else $error("empty queue with nonzero earliest deadline");

	// Single-result kinds other than a removal carry no handler and close the request
	a_single: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (kind == K_INSERTED || kind == K_DROPPED || kind == K_NOT_FOUND
			|| kind == K_NONE) |-> (out_handler == '0) && is_last)
		else $error("single result with handler or without last mark");

	// A successful insert leaves the queue non-empty
	a_insert_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (kind == K_INSERTED) |-> entries_left != '0)
		else $error("insert left an empty queue");

endmodule

bind sorted_timer_queue_core stq_checker #(
	.QUEUE_DEPTH  (QUEUE_DEPTH),
	.HANDLER_BITS (HANDLER_BITS)
) u_stq_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (out.valid),
	.out_ready     (out.ready),
	.kind          (out.kind),
	.out_handler   (out.out_handler),
	.is_last       (out.is_last),
	.entries_left  (out.entries_left),
	.earliest_sec  (out.earliest_sec),
	.earliest_usec (out.earliest_usec)
);

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
	import stq_pkg::*;

	localparam int         DEPTH        = QUEUE_DEPTH_DEF;
	localparam int         RANDOM_ITEMS = 415;
	localparam int         CALM_ITEMS   = 60;
	localparam int         STALL_LIMIT  = 4000;
	localparam logic [1:0] CMD_UNUSED   = 2'd3;

	// One result as the block should give it
	typedef struct packed {
		kind_t       kind;
		logic [7:0]  handler;
		logic        last;
		logic [4:0]  left;
		logic [31:0] head_sec;
		logic [19:0] head_usec;
	} timer_result_t;

	// One line of the directed plan
	typedef struct {
		logic [1:0]    cmd;
		logic [31:0]   sec;
		logic [19:0]   usec;
		logic [7:0]    handler;
		int            reps;
		bit            fixed;
		timer_result_t fixed_res;
	} plan_row_t;

	logic clk = 1'b0;
	logic arst_n;

	stq_req_if req_ch();
	stq_rsp_if rsp_ch();

	sorted_timer_queue_core DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.in     (req_ch.sink),
		.out    (rsp_ch.source)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Shadow copy of the timer queue
	logic [31:0] shadow_sec [DEPTH];
	logic [19:0] shadow_usec [DEPTH];
	logic [7:0]  shadow_hid [DEPTH];
	int          shadow_count = 0;

	timer_result_t due_results[$];
	int            mismatches   = 0;
	int            results_seen = 0;
	int            requests     = 0;
	int            ignored      = 0;
	int            kind_tally [6];
	int            longest_pop  = 0;
	bit            calm         = 1'b0;
	int            stall_left   = 0;
	int            quiet_cycles = 0;

	task automatic report_error(input string msg);
		$display("[%0t] ERROR: %s", $realtime, msg);
		mismatches++;
	endtask

	function automatic bit sooner(input logic [31:0] as, input logic [19:0] au,
			input logic [31:0] bs, input logic [19:0] bu);
		return (as < bs) || (as == bs && au < bu);
	endfunction

	function automatic timer_result_t snapshot(input kind_t k, input logic [7:0] h,
			input logic last);
		timer_result_t r;
		r.kind      = k;
		r.handler   = h;
		r.last      = last;
		r.left      = 5'(shadow_count);
		r.head_sec  = shadow_count != 0 ? shadow_sec[0] : 32'd0;
		r.head_usec = shadow_count != 0 ? shadow_usec[0] : 20'd0;
		return r;
	endfunction

	// Close the gap left by slot p and clear the freed tail slot
	function automatic void close_slot(input int p);
		for (int i = p; i + 1 < shadow_count; i++) begin
			shadow_sec[i]  = shadow_sec[i + 1];
			shadow_usec[i] = shadow_usec[i + 1];
			shadow_hid[i]  = shadow_hid[i + 1];
		end
		shadow_count--;
		shadow_sec[shadow_count]  = '0;
		shadow_usec[shadow_count] = '0;
		shadow_hid[shadow_count]  = '0;
	endfunction

	// Apply one request to the shadow queue and list the results it causes
	function automatic void apply_timer_request(input logic [1:0] cmd,
			input logic [31:0] sec, input logic [19:0] usec, input logic [7:0] hid,
			output timer_result_t res [MAX_RESULTS], output int n);
		int p;
		n = 0;
		case (cmd)
			CMD_INSERT: begin
				if (shadow_count >= DEPTH) begin
					res[0] = snapshot(K_DROPPED, 8'd0, 1'b1);
					n = 1;
				end else begin
					// only a strictly earlier time displaces the head
					if (shadow_count == 0 ||
							sooner(sec, usec, shadow_sec[0], shadow_usec[0])) begin
						p = 0;
					end else begin
						p = 1;
						while (p < shadow_count &&
								sooner(shadow_sec[p], shadow_usec[p], sec, usec))
							p++;
					end
					for (int i = shadow_count; i > p; i--) begin
						shadow_sec[i]  = shadow_sec[i - 1];
						shadow_usec[i] = shadow_usec[i - 1];
						shadow_hid[i]  = shadow_hid[i - 1];
					end
					shadow_sec[p]  = sec;
					shadow_usec[p] = usec;
					shadow_hid[p]  = hid;
					shadow_count++;
					res[0] = snapshot(K_INSERTED, 8'd0, 1'b1);
					n = 1;
				end
			end
			CMD_REMOVE: begin
				p = 0;
				while (p < shadow_count && shadow_hid[p] != hid)
					p++;
				if (p >= shadow_count) begin
					res[0] = snapshot(K_NOT_FOUND, 8'd0, 1'b1);
				end else begin
					close_slot(p);
					res[0] = snapshot(K_REMOVED, hid, 1'b1);
				end
				n = 1;
			end
			CMD_EXPIRE: begin
				while (n < MAX_RESULTS && shadow_count > 0 &&
						sooner(shadow_sec[0], shadow_usec[0], sec, usec)) begin
					logic [7:0] h;
					h = shadow_hid[0];
					close_slot(0);
					res[n] = snapshot(K_EXPIRED, h, 1'b0);
					n++;
				end
				if (n == 0) begin
					res[0] = snapshot(K_NONE, 8'd0, 1'b1);
					n = 1;
				end else begin
					res[n - 1].last = 1'b1;
				end
			end
			default: n = 0;
		endcase
	endfunction

	function automatic plan_row_t plain_row(input logic [1:0] cmd, input logic [31:0] sec,
			input logic [19:0] usec, input logic [7:0] hid, input int reps);
		plan_row_t r;
		r.cmd       = cmd;
		r.sec       = sec;
		r.usec      = usec;
		r.handler   = hid;
		r.reps      = reps;
		r.fixed     = 1'b0;
		r.fixed_res = '0;
		return r;
	endfunction

	function automatic plan_row_t fixed_row(input logic [1:0] cmd, input logic [31:0] sec,
			input logic [19:0] usec, input logic [7:0] hid, input kind_t k,
			input logic [7:0] h_out, input logic [4:0] left, input logic [31:0] hs,
			input logic [19:0] hu);
		plan_row_t r;
		r = plain_row(cmd, sec, usec, hid, 1);
		r.fixed     = 1'b1;
		r.fixed_res = '{kind: k, handler: h_out, last: 1'b1, left: left,
			head_sec: hs, head_usec: hu};
		return r;
	endfunction

	function automatic logic [19:0] pick_usec();
		case ($urandom_range(0, 5))
			0:       return 20'd0;
			1:       return 20'd999999;
			2:       return 20'hFFFFF;
			5:       return 20'($urandom_range(0, 20'hFFFFF));
			default: return 20'($urandom_range(0, 9));
		endcase
	endfunction

	// Hold the request until the block takes it
	task automatic offer(input logic [1:0] cmd, input logic [31:0] sec,
			input logic [19:0] usec, input logic [7:0] hid);
		req_ch.valid      <= 1'b1;
		req_ch.cmd        <= cmd;
		req_ch.time_sec   <= sec;
		req_ch.time_usec  <= usec;
		req_ch.handler_id <= hid;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
	endtask

	// Send one request, then queue up what it should produce
	task automatic issue(input plan_row_t row);
		timer_result_t res [MAX_RESULTS];
		int            n;
		offer(row.cmd, row.sec, row.usec, row.handler);
		requests++;
		apply_timer_request(row.cmd, row.sec, row.usec, row.handler, res, n);
		if (n == 0)
			ignored++;
		if (row.fixed) begin
			due_results.push_back(row.fixed_res);
			kind_tally[row.fixed_res.kind]++;
		end else begin
			for (int i = 0; i < n; i++) begin
				due_results.push_back(res[i]);
				kind_tally[res[i].kind]++;
			end
		end
		if (row.cmd == CMD_EXPIRE && n > longest_pop)
			longest_pop = n;
		// occasional gap on the request side
		if (!calm && $urandom_range(0, 3) == 0) begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
	endtask

	// Result side back-pressure in bursts
	always @(posedge clk) begin
		if (!calm && stall_left == 0 && $urandom_range(0, 5) == 0)
			stall_left = $urandom_range(1, 8);
		if (stall_left > 0) begin
			rsp_ch.ready <= 1'b0;
			stall_left--;
		end else begin
			rsp_ch.ready <= 1'b1;
		end
	end

	// Compare every accepted result with the oldest one due
	always @(posedge clk) begin : check_results
		timer_result_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			results_seen++;
			if (due_results.size() == 0) begin
				report_error($sformatf("result kind %0d with nothing outstanding",
					rsp_ch.kind));
			end else begin
				want = due_results.pop_front();
				if (rsp_ch.kind !== want.kind)
					report_error($sformatf("result %0d kind %0d, want %0d",
						results_seen, rsp_ch.kind, want.kind));
				if (rsp_ch.out_handler !== want.handler)
					report_error($sformatf("result %0d handler 0x%0h, want 0x%0h",
						results_seen, rsp_ch.out_handler, want.handler));
				if (rsp_ch.is_last !== want.last)
					report_error($sformatf("result %0d is_last %0b, want %0b",
						results_seen, rsp_ch.is_last, want.last));
				if (rsp_ch.entries_left !== want.left)
					report_error($sformatf("result %0d entries_left %0d, want %0d",
						results_seen, rsp_ch.entries_left, want.left));
				if (rsp_ch.earliest_sec !== want.head_sec)
					report_error($sformatf("result %0d earliest_sec 0x%0h, want 0x%0h",
						results_seen, rsp_ch.earliest_sec, want.head_sec));
				if (rsp_ch.earliest_usec !== want.head_usec)
					report_error($sformatf("result %0d earliest_usec 0x%0h, want 0x%0h",
						results_seen, rsp_ch.earliest_usec, want.head_usec));
			end
		end
	end

	// Watchdog on cycles with no handshake on either side
	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("timeout after %0d cycles without a handshake", quiet_cycles);
			$display("end of test: mismatches");
			$finish;
		end
	end

	initial begin : stimulus
		plan_row_t   plan[$];
		plan_row_t   row;
		logic [31:0] epoch;
		int          r;
		int          done;
		bit          wild;

		arst_n            <= 1'b0;
		req_ch.valid      <= 1'b0;
		req_ch.cmd        <= CMD_INSERT;
		req_ch.time_sec   <= '0;
		req_ch.time_usec  <= '0;
		req_ch.handler_id <= '0;
		foreach (kind_tally[i])
			kind_tally[i] = 0;
		foreach (shadow_sec[i]) begin
			shadow_sec[i]  = '0;
			shadow_usec[i] = '0;
			shadow_hid[i]  = '0;
		end
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: empty queue, extremes, ties, misses, full queue, long expire
		plan.push_back(fixed_row(CMD_EXPIRE, 32'd0, 20'd0, 8'd0, K_NONE, 8'd0, 5'd0, 32'd0,
			20'd0));
		plan.push_back(fixed_row(CMD_REMOVE, 32'd0, 20'd0, 8'd0, K_NOT_FOUND, 8'd0, 5'd0, 32'd0,
			20'd0));
		plan.push_back(fixed_row(CMD_INSERT, 32'd100, 20'd5, 8'd1, K_INSERTED, 8'd0, 5'd1, 32'd100,
			20'd5));
		plan.push_back(fixed_row(CMD_INSERT, 32'hFFFFFFFF, 20'hFFFFE, 8'hFF, K_INSERTED, 8'd0, 5'd2,
			32'd100, 20'd5));
		plan.push_back(fixed_row(CMD_INSERT, 32'd0, 20'd0, 8'd0, K_INSERTED, 8'd0, 5'd3, 32'd0,
			20'd0));
		plan.push_back(plain_row(CMD_INSERT, 32'd100, 20'd5, 8'd2, 1));
		plan.push_back(plain_row(CMD_INSERT, 32'd100, 20'd5, 8'd3, 1));
		plan.push_back(plain_row(CMD_INSERT, 32'd0, 20'd0, 8'd5, 1));
		plan.push_back(plain_row(CMD_UNUSED, 32'hFFFFFFFF, 20'hFFFFF, 8'hFF, 1));
		plan.push_back(plain_row(CMD_INSERT, 32'd100, 20'd4, 8'd4, 1));
		plan.push_back(plain_row(CMD_REMOVE, 32'd0, 20'd0, 8'd2, 1));
		plan.push_back(plain_row(CMD_REMOVE, 32'd0, 20'd0, 8'h55, 1));
		plan.push_back(plain_row(CMD_EXPIRE, 32'd100, 20'd5, 8'd0, 1));
		plan.push_back(plain_row(CMD_INSERT, 32'd200, 20'd999999, 8'h80, 13));
		plan.push_back(fixed_row(CMD_INSERT, 32'd1, 20'd1, 8'h7F, K_DROPPED, 8'd0, 5'd16, 32'd100,
			20'd5));
		plan.push_back(plain_row(CMD_EXPIRE, 32'hFFFFFFFF, 20'hFFFFF, 8'd0, 1));
		plan.push_back(fixed_row(CMD_REMOVE, 32'd0, 20'd0, 8'hFF, K_NOT_FOUND, 8'd0, 5'd0, 32'd0,
			20'd0));

		foreach (plan[i]) begin
			for (int k = 0; k < plan[i].reps; k++) begin
				row = plan[i];
				row.sec     = plan[i].sec + 32'(k);
				row.handler = plan[i].handler + 8'(k);
				issue(row);
			end
		end

		// Random traffic around a slowly moving notion of now
		epoch = 32'($urandom_range(0, 1000));
		done  = 0;
		while (done < RANDOM_ITEMS) begin
			calm = (done >= RANDOM_ITEMS - CALM_ITEMS);
			r    = $urandom_range(0, 99);
			wild = ($urandom_range(0, 15) == 0);
			row  = plain_row(CMD_INSERT, '0, '0, '0, 1);
			if (r < 4) begin
				row.cmd     = CMD_UNUSED;
				row.sec     = $urandom;
				row.usec    = 20'($urandom);
				row.handler = 8'($urandom);
			end else if (r < 50) begin
				row.cmd     = CMD_INSERT;
				row.sec     = wild ? $urandom : epoch + 32'($urandom_range(0, 6));
				row.usec    = pick_usec();
				row.handler = ($urandom_range(0, 3) == 0) ? 8'($urandom) :
					8'($urandom_range(0, 15));
			end else if (r < 68) begin
				row.cmd = CMD_REMOVE;
				if (shadow_count > 0 && $urandom_range(0, 3) != 0)
					row.handler = shadow_hid[$urandom_range(0, shadow_count - 1)];
				else
					row.handler = 8'($urandom);
				row.sec  = $urandom;
				row.usec = 20'($urandom);
			end else begin
				row.cmd     = CMD_EXPIRE;
				row.sec     = wild ? $urandom : epoch + 32'($urandom_range(0, 4));
				row.usec    = pick_usec();
				row.handler = 8'($urandom);
				epoch       = epoch + 32'($urandom_range(0, 2));
			end
			issue(row);
			if (row.cmd != CMD_UNUSED)
				done++;
		end
		req_ch.valid <= 1'b0;

		// Drain, then allow a little settling time for strays
		while (due_results.size() > 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (due_results.size() > 0)
			report_error($sformatf("%0d results never arrived", due_results.size()));

		$display("%0d requests (%0d unknown commands), %0d results checked",
			requests, ignored, results_seen);
		$display("inserted %0d, dropped %0d, removed %0d, missed %0d, expired %0d, %s",
			kind_tally[K_INSERTED], kind_tally[K_DROPPED], kind_tally[K_REMOVED],
			kind_tally[K_NOT_FOUND], kind_tally[K_EXPIRED],
			$sformatf("idle %0d; longest expire %0d", kind_tally[K_NONE], longest_pop));
		if (mismatches == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
